// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cst_pkg.sv =====
// Package for the cursor sequence table: operation and error codes,
// controller states and fixed port widths. No dependencies.
package cst_pkg;

    localparam int OP_BITS     = 4;
    localparam int VALUE_BITS  = 64;
    localparam int POS_BITS    = 5;
    localparam int COUNT_BITS  = 6;
    localparam int ERR_BITS    = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_START    = 4'd0,
        OP_END      = 4'd1,
        OP_LAST     = 4'd2,
        OP_ADVANCE  = 4'd3,
        OP_RETREAT  = 4'd4,
        OP_INSERT   = 4'd5,
        OP_ATTACH   = 4'd6,
        OP_REMOVE   = 4'd7,
        OP_FRONT    = 4'd8,
        OP_BACK     = 4'd9,
        OP_POPFRONT = 4'd10,
        OP_READCUR  = 4'd11,
        OP_READIDX  = 4'd12
    } op_t;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FIN,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// ===== design/cursor_sequence_table.sv =====
// Cursor sequence table: bounded ordered word store with one cursor, held in a memory
// with one read and one write port that moves one entry per cycle.
// Cursor moves and refused requests go straight to the result register; reads pass through
// the memory read register; insert/attach/front/back first shift the entries from the
// position up and then write the new word, and remove/popfront shift later entries down.
// One item at a time (s_ready only while idle); active-low sync reset empties the store.
module cursor_sequence_table #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cst_pkg::OP_BITS-1:0]     s_operation,
    input  logic [cst_pkg::VALUE_BITS-1:0]  s_value,
    input  logic [cst_pkg::POS_BITS-1:0]    s_position,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cst_pkg::VALUE_BITS-1:0]  m_read_word,
    output logic [cst_pkg::COUNT_BITS-1:0]  m_item_count,
    output logic [cst_pkg::COUNT_BITS-1:0]  m_cursor_pos,
    output logic                            m_has_item,
    output logic [cst_pkg::ERR_BITS-1:0]    m_error_code
);
    import cst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_BITS) ? CW : COUNT_BITS;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, cursor_reg, moves_reg;
    logic                   wr_pend_reg, open_reg, m_valid_reg;
    logic [WORD_BITS-1:0]   word_reg, res_word_reg, rd_data_reg;
    logic [AW-1:0]          rd_ptr_reg, wr_ptr_reg, fin_ptr_reg;
    err_t                   err_reg;
    logic [VALUE_BITS-1:0]  m_read_word_reg;
    logic [COUNT_BITS-1:0]  m_item_count_reg, m_cursor_pos_reg;
    logic                   m_has_item_reg;
    err_t                   m_error_code_reg;

    logic [WORD_BITS-1:0]   entries_mem [DEPTH];

    // accept-time decode
    logic                   cur_valid, full, do_open, do_close;
    logic [XW-1:0]          pos_ext, count_ext, cursor_ext;
    logic [CW-1:0]          open_pos, close_pos;
    logic [CW-1:0]          dec_count, dec_cursor, dec_moves;
    logic [AW-1:0]          dec_ptr, dec_fin, dec_raddr;
    logic                   dec_open;
    err_t                   dec_err;
    state_t                 dec_state;

    // memory port controls
    logic                   mem_re, mem_we;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;

    logic                   out_load;
    logic [VALUE_BITS-1:0]  res_word_ext;

    always_comb begin
        cur_valid  = cursor_reg < count_reg;
        full       = count_reg == CW'(DEPTH);
        pos_ext    = XW'(s_position);
        count_ext  = XW'(count_reg);
        cursor_ext = XW'(cursor_reg);
        do_open    = 1'b0;
        do_close   = 1'b0;
        open_pos   = '0;
        close_pos  = '0;
        dec_count  = count_reg;
        dec_cursor = cursor_reg;
        dec_moves  = '0;
        dec_ptr    = '0;
        dec_fin    = '0;
        dec_raddr  = '0;
        dec_open   = 1'b0;
        dec_err    = ERR_OK;
        dec_state  = ST_DONE;
        unique case (op_t'(s_operation))
            OP_START: begin
                dec_cursor = '0;
            end
            OP_END: begin
                dec_cursor = (count_reg != '0) ? count_reg - 1'b1 : '0;
            end
            OP_LAST: begin
                dec_cursor = CW'(DEPTH - 1);
            end
            OP_ADVANCE: begin
                if (cur_valid) dec_cursor = cursor_reg + 1'b1;
                else           dec_err = ERR_EMPTY;
            end
            OP_RETREAT: begin
                if (cursor_reg != '0) dec_cursor = cursor_reg - 1'b1;
            end
            OP_INSERT: begin
                if (full) begin
                    dec_err = ERR_FULL;
                end else begin
                    do_open  = 1'b1;
                    open_pos = cur_valid ? cursor_reg : '0;
                end
            end
            OP_ATTACH: begin
                if (full) begin
                    dec_err = ERR_FULL;
                end else begin
                    do_open  = 1'b1;
                    open_pos = cur_valid ? cursor_reg + 1'b1 : count_reg;
                end
            end
            OP_REMOVE: begin
                if (!cur_valid) begin
                    dec_err = ERR_EMPTY;
                end else begin
                    do_close  = 1'b1;
                    close_pos = cursor_reg;
                end
            end
            OP_FRONT: begin
                if (full) begin
                    dec_err = ERR_FULL;
                end else begin
                    do_open  = 1'b1;
                    open_pos = '0;
                end
            end
            OP_BACK: begin
                if (full) begin
                    dec_err = ERR_FULL;
                end else begin
                    do_open  = 1'b1;
                    open_pos = count_reg;
                end
            end
            OP_POPFRONT: begin
                if (count_reg == '0) begin
                    dec_err = ERR_EMPTY;
                end else begin
                    do_close   = 1'b1;
                    close_pos  = '0;
                    dec_cursor = '0;
                end
            end
            OP_READCUR: begin
                if (cur_valid) begin
                    dec_raddr = AW'(cursor_ext);
                    dec_state = ST_READ;
                end else begin
                    dec_err = ERR_EMPTY;
                end
            end
            OP_READIDX: begin
                if (pos_ext < count_ext) begin
                    dec_raddr = AW'(pos_ext);
                    dec_state = ST_READ;
                end else begin
                    dec_err = ERR_RANGE;
                end
            end
            default: begin
            end
        endcase

        // open: move count-1 .. pos up by one, then drop the word at pos
        if (do_open) begin
            dec_cursor = open_pos;
            dec_count  = count_reg + 1'b1;
            dec_moves  = count_reg - open_pos;
            dec_ptr    = AW'(count_reg - 1'b1);
            dec_fin    = AW'(open_pos);
            dec_open   = 1'b1;
            dec_state  = ST_SHIFT;
        end
        // close: move pos+1 .. count-1 down by one
        if (do_close) begin
            dec_count  = count_reg - 1'b1;
            dec_moves  = count_reg - 1'b1 - close_pos;
            dec_ptr    = AW'(close_pos + 1'b1);
            dec_state  = ST_SHIFT;
        end
    end

    assign out_load = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = dec_state;
            end
            ST_SHIFT: begin
                if (moves_reg == '0 && !wr_pend_reg) begin
                    state_next = open_reg ? ST_FIN : ST_DONE;
                end
            end
            ST_FIN: begin
                state_next = ST_DONE;
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port controls
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mem_re    = s_valid && (dec_state == ST_READ);
                mem_raddr = dec_raddr;
            end
            ST_SHIFT: begin
                mem_re    = moves_reg != '0;
                mem_raddr = rd_ptr_reg;
                mem_we    = wr_pend_reg;
                mem_waddr = wr_ptr_reg;
            end
            ST_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = fin_ptr_reg;
                mem_wdata = word_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) entries_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= entries_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            moves_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_valid) begin
                count_reg   <= dec_count;
                cursor_reg  <= dec_cursor;
                moves_reg   <= dec_moves;
                wr_pend_reg <= 1'b0;
            end else if (state_reg == ST_SHIFT) begin
                wr_pend_reg <= moves_reg != '0;
                if (moves_reg != '0) moves_reg <= moves_reg - 1'b1;
            end
            if (state_reg == ST_DONE && out_load) m_valid_reg <= 1'b1;
            else if (m_ready)                     m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        res_word_ext = '0;
        res_word_ext[WORD_BITS-1:0] = res_word_reg;
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            word_reg     <= s_value[WORD_BITS-1:0];
            err_reg      <= dec_err;
            open_reg     <= dec_open;
            rd_ptr_reg   <= dec_ptr;
            fin_ptr_reg  <= dec_fin;
            res_word_reg <= '0;
        end
        if (state_reg == ST_SHIFT && moves_reg != '0) begin
            rd_ptr_reg <= open_reg ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
            wr_ptr_reg <= open_reg ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;
        end
        if (state_reg == ST_READ) res_word_reg <= rd_data_reg;
        if (state_reg == ST_DONE && out_load) begin
            m_read_word_reg  <= res_word_ext;
            m_item_count_reg <= count_ext[COUNT_BITS-1:0];
            m_cursor_pos_reg <= cursor_ext[COUNT_BITS-1:0];
            m_has_item_reg   <= cur_valid;
            m_error_code_reg <= err_reg;
        end
    end

    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_read_word  = m_read_word_reg;
    assign m_item_count = m_item_count_reg;
    assign m_cursor_pos = m_cursor_pos_reg;
    assign m_has_item   = m_has_item_reg;
    assign m_error_code = m_error_code_reg;

endmodule

// ===== design/cst_check.sv =====
// Port-level checker for the cursor sequence table, bound to the top level.
// Depends on cst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cst_check #(
    parameter int DEPTH = 32
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [cst_pkg::VALUE_BITS-1:0]  m_read_word,
    input logic [cst_pkg::COUNT_BITS-1:0]  m_item_count,
    input logic [cst_pkg::COUNT_BITS-1:0]  m_cursor_pos,
    input logic                            m_has_item,
    input logic [cst_pkg::ERR_BITS-1:0]    m_error_code
);
    import cst_pkg::*;

    `ASSERT_CLK_NR(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `ASSERT_CLK(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_word) && $stable(m_error_code), "stalled result changed")

    `ASSERT_CLK(a_word_only_ok, aclk, aresetn, m_valid && (m_read_word != 0) |-> m_error_code == ERR_OK, "nonzero word with error")

    `ASSERT_CLK(a_item_flag, aclk, aresetn, m_valid && (DEPTH < 63) |-> m_has_item == (m_cursor_pos < m_item_count), "item flag disagrees with cursor")

    `ASSERT_CLK(a_full_count, aclk, aresetn, m_valid && (DEPTH < 63) && (m_error_code == ERR_FULL) |-> m_item_count == 6'(DEPTH), "full error below capacity")

endmodule

bind cursor_sequence_table cst_check #(.DEPTH(DEPTH)) u_cst_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_word  (m_read_word),
    .m_item_count (m_item_count),
    .m_cursor_pos (m_cursor_pos),
    .m_has_item   (m_has_item),
    .m_error_code (m_error_code)
);
